/* rtl/core/ssbi_pkg.sv */
// shared types, codes and lane functions for the simd shift-by-immediate unit
`default_nettype none

package ssbi_pkg;

  // stream widths, padded to whole bytes
  localparam int IN_W  = 272;
  localparam int OUT_W = 136;

  // operation codes
  localparam logic [3:0] OP_SSHR  = 4'd0;
  localparam logic [3:0] OP_USHR  = 4'd1;
  localparam logic [3:0] OP_SSRA  = 4'd2;
  localparam logic [3:0] OP_USRA  = 4'd3;
  localparam logic [3:0] OP_SRSHR = 4'd4;
  localparam logic [3:0] OP_URSHR = 4'd5;
  localparam logic [3:0] OP_SRSRA = 4'd6;
  localparam logic [3:0] OP_URSRA = 4'd7;
  localparam logic [3:0] OP_SHL   = 4'd8;
  localparam logic [3:0] OP_SLI   = 4'd9;
  localparam logic [3:0] OP_SRI   = 4'd10;
  localparam logic [3:0] OP_SHRN  = 4'd11;
  localparam logic [3:0] OP_RSHRN = 4'd12;
  localparam logic [3:0] OP_SSHLL = 4'd13;
  localparam logic [3:0] OP_USHLL = 4'd14;
  // the one unassigned operation code
  localparam logic [3:0] OP_UNDEF = 4'd15;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DECODE   = 2'd1;
  localparam logic [1:0] ST_RESERVED = 2'd2;

  // lane size codes
  localparam logic [1:0] SZ_8  = 2'd0;
  localparam logic [1:0] SZ_16 = 2'd1;
  localparam logic [1:0] SZ_32 = 2'd2;
  localparam logic [1:0] SZ_64 = 2'd3;

  // operation family
  typedef enum logic [1:0] {
    CL_SHIFT,
    CL_NARROW,
    CL_WIDEN
  } op_class_t;

  // one instruction as held in the input register
  typedef struct packed {
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [2:0]  immb;
    logic [3:0]  immh;
    logic        q;
    logic [3:0]  mode;
  } op_item_t;

  // decoded control for the lane logic
  typedef struct packed {
    logic [1:0] status;
    op_class_t  cls;
    logic [1:0] sz;
    logic [6:0] rs;
    logic [5:0] ls;
  } dec_t;

  // one result item
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] res_hi;
    logic [63:0] res_lo;
  } res_item_t;

  function automatic logic [63:0] lane_mask(input logic [1:0] sz);
    logic [63:0] m;
    case (sz)
      SZ_8:    m = 64'h0000_0000_0000_00FF;
      SZ_16:   m = 64'h0000_0000_0000_FFFF;
      SZ_32:   m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

  // sign extension from the lane width to 64 bits
  function automatic logic [63:0] sext(input logic [63:0] x, input logic [1:0] sz);
    logic [63:0] lm;
    logic        top;
    lm  = lane_mask(sz);
    top = |(x & (lm ^ (lm >> 1)));
    return (x & lm) | (top ? ~lm : 64'd0);
  endfunction

  // right shift of one lane, arithmetic when sgn, shift of 1 to 64
  function automatic logic [63:0] shr_lane(input logic [63:0] x, input logic [1:0] sz,
                                           input logic [6:0] s, input logic sgn);
    logic [63:0]        lm;
    logic [63:0]        v;
    logic               ext;
    logic signed [64:0] w;
    lm  = lane_mask(sz);
    ext = sgn & (|(x & (lm ^ (lm >> 1))));
    v   = (x & lm) | (ext ? ~lm : 64'd0);
    w   = $signed({ext, v}) >>> s;
    return w[63:0] & lm;
  endfunction

  function automatic logic [63:0] shl_lane(input logic [63:0] x, input logic [1:0] sz,
                                           input logic [5:0] s);
    return (x << s) & lane_mask(sz);
  endfunction

  // last bit shifted out, for rounding
  function automatic logic round_bit(input logic [63:0] x, input logic [6:0] s);
    logic [6:0] k;
    k = s - 7'd1;
    return x[k[5:0]];
  endfunction

  // same-size shift, accumulate and insert forms
  function automatic logic [63:0] lane_op(input logic [3:0] mode, input logic [63:0] x,
                                          input logic [63:0] d, input logic [1:0] sz,
                                          input logic [6:0] rs, input logic [5:0] ls);
    logic [63:0] r;
    logic [63:0] m;
    logic [63:0] lm;
    lm = lane_mask(sz);
    r  = 64'd0;
    if (mode <= OP_URSRA) begin
      r = shr_lane(x, sz, rs, ~mode[0]);
      if (mode >= OP_SRSHR) r = r + {63'd0, round_bit(x, rs)};
      if (mode[1]) r = r + d;
    end else if (mode == OP_SHL) begin
      r = shl_lane(x, sz, ls);
    end else if (mode == OP_SLI) begin
      m = shl_lane(lm, sz, ls);
      r = (d & ~m) | shl_lane(x, sz, ls);
    end else if (mode == OP_SRI) begin
      m = shr_lane(lm, sz, rs, 1'b0);
      r = (d & ~m) | shr_lane(x, sz, rs, 1'b0);
    end
    return r & lm;
  endfunction

  // narrowing right shift of a double-width lane, rounding carry kept before truncation
  function automatic logic [63:0] nar_lane(input logic [63:0] x, input logic [1:0] sz_w,
                                           input logic [6:0] rs, input logic rnd);
    logic [63:0] r;
    r = shr_lane(x, sz_w, rs, 1'b0);
    if (rnd) r = r + {63'd0, round_bit(x, rs)};
    return r;
  endfunction

  // widening left shift, sz_n is the narrow lane size
  function automatic logic [63:0] wid_lane(input logic [63:0] x, input logic [1:0] sz_n,
                                           input logic [5:0] ls, input logic sgn);
    logic [63:0] v;
    v = sgn ? sext(x, sz_n) : (x & lane_mask(sz_n));
    return shl_lane(v, sz_n + 2'd1, ls);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ssbi_in_stage.sv */
// input register with stream handshake
`default_nettype none

module ssbi_in_stage
  import ssbi_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [IN_W-1:0] s_tdata,
  input  wire logic            take,
  output logic                 valid,
  output op_item_t             item
);

  // ready whenever the register is empty or moves on this cycle
  assign s_tready = !valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_tdata[$bits(op_item_t)-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ssbi_decode.sv */
// immediate decode: lane size, shift amounts, status and operation family
`default_nettype none

module ssbi_decode
  import ssbi_pkg::*;
(
  input  wire op_item_t item,
  output dec_t          dec
);

  logic [1:0] hsb;
  logic [6:0] imm;
  logic [7:0] esz;
  logic [7:0] rs_w;
  logic [6:0] ls_w;
  logic       reserved;

  // lane size from the highest set bit of immh
  always_comb begin
    if (item.immh[3])      hsb = SZ_64;
    else if (item.immh[2]) hsb = SZ_32;
    else if (item.immh[1]) hsb = SZ_16;
    else                   hsb = SZ_8;
  end

  // shift amounts
  assign imm  = {item.immh, item.immb};
  assign esz  = 8'd8 << hsb;
  assign rs_w = (esz << 1) - {1'b0, imm};
  assign ls_w = imm - esz[6:0];

  // reserved encodings
  assign reserved = (item.mode > OP_USHLL) ||
                    (item.immh[3] && ((item.mode >= OP_SHRN) || !item.q));

  always_comb begin
    dec.sz = hsb;
    dec.rs = rs_w[6:0];
    dec.ls = ls_w[5:0];
    if (item.immh == 4'd0)  dec.status = ST_DECODE;
    else if (reserved)      dec.status = ST_RESERVED;
    else                    dec.status = ST_OK;
    if (item.mode >= OP_SSHLL)     dec.cls = CL_WIDEN;
    else if (item.mode >= OP_SHRN) dec.cls = CL_NARROW;
    else                           dec.cls = CL_SHIFT;
  end

endmodule

`default_nettype wire

/* rtl/core/ssbi_lanes.sv */
// lane datapath for every lane size, then selection of the new destination
`default_nettype none

module ssbi_lanes
  import ssbi_pkg::*;
(
  input  wire op_item_t item,
  input  wire dec_t     dec,
  output res_item_t     res
);

  logic [127:0] src;
  logic [127:0] dst;
  logic [63:0]  half;
  logic [127:0] sh8, sh16, sh32, sh64;
  logic [63:0]  nw8, nw16, nw32;
  logic [127:0] wd8, wd16, wd32;
  logic         rnd;
  logic         sgn_w;

  assign src   = {item.src_hi, item.src_lo};
  assign dst   = {item.dst_hi, item.dst_lo};
  assign half  = item.q ? item.src_hi : item.src_lo;
  assign rnd   = (item.mode == OP_RSHRN);
  assign sgn_w = (item.mode == OP_SSHLL);

  // same-size lanes
  always_comb begin
    logic [63:0] t;
    t = 64'd0;
    for (int i = 0; i < 16; i++) begin
      t = lane_op(item.mode, {56'd0, src[i*8 +: 8]}, {56'd0, dst[i*8 +: 8]},
                  SZ_8, dec.rs, dec.ls);
      sh8[i*8 +: 8] = t[7:0];
    end
    for (int i = 0; i < 8; i++) begin
      t = lane_op(item.mode, {48'd0, src[i*16 +: 16]}, {48'd0, dst[i*16 +: 16]},
                  SZ_16, dec.rs, dec.ls);
      sh16[i*16 +: 16] = t[15:0];
    end
    for (int i = 0; i < 4; i++) begin
      t = lane_op(item.mode, {32'd0, src[i*32 +: 32]}, {32'd0, dst[i*32 +: 32]},
                  SZ_32, dec.rs, dec.ls);
      sh32[i*32 +: 32] = t[31:0];
    end
    for (int i = 0; i < 2; i++) begin
      t = lane_op(item.mode, src[i*64 +: 64], dst[i*64 +: 64], SZ_64, dec.rs, dec.ls);
      sh64[i*64 +: 64] = t;
    end
  end

  // narrowing lanes, double-width sources across the whole vector
  always_comb begin
    logic [63:0] t;
    t = 64'd0;
    for (int i = 0; i < 8; i++) begin
      t = nar_lane({48'd0, src[i*16 +: 16]}, SZ_16, dec.rs, rnd);
      nw8[i*8 +: 8] = t[7:0];
    end
    for (int i = 0; i < 4; i++) begin
      t = nar_lane({32'd0, src[i*32 +: 32]}, SZ_32, dec.rs, rnd);
      nw16[i*16 +: 16] = t[15:0];
    end
    for (int i = 0; i < 2; i++) begin
      t = nar_lane(src[i*64 +: 64], SZ_64, dec.rs, rnd);
      nw32[i*32 +: 32] = t[31:0];
    end
  end

  // widening lanes from the selected source half
  always_comb begin
    logic [63:0] t;
    t = 64'd0;
    for (int i = 0; i < 8; i++) begin
      t = wid_lane({56'd0, half[i*8 +: 8]}, SZ_8, dec.ls, sgn_w);
      wd8[i*16 +: 16] = t[15:0];
    end
    for (int i = 0; i < 4; i++) begin
      t = wid_lane({48'd0, half[i*16 +: 16]}, SZ_16, dec.ls, sgn_w);
      wd16[i*32 +: 32] = t[31:0];
    end
    for (int i = 0; i < 2; i++) begin
      t = wid_lane({32'd0, half[i*32 +: 32]}, SZ_32, dec.ls, sgn_w);
      wd32[i*64 +: 64] = t;
    end
  end

  // pick the lane size and the form, keep the destination on any error
  always_comb begin
    logic [127:0] r;
    logic [63:0]  w;
    r = dst;
    w = 64'd0;
    case (dec.cls)
      CL_SHIFT: begin
        case (dec.sz)
          SZ_8:    r = sh8;
          SZ_16:   r = sh16;
          SZ_32:   r = sh32;
          default: r = sh64;
        endcase
        if (!item.q) r[127:64] = 64'd0;
      end
      CL_NARROW: begin
        case (dec.sz)
          SZ_8:    w = nw8;
          SZ_16:   w = nw16;
          default: w = nw32;
        endcase
        r = item.q ? {w, item.dst_lo} : {64'd0, w};
      end
      CL_WIDEN: begin
        case (dec.sz)
          SZ_8:    r = wd8;
          SZ_16:   r = wd16;
          default: r = wd32;
        endcase
      end
      default: r = dst;
    endcase
    if (dec.status != ST_OK) r = dst;
    res.status = dec.status;
    res.res_lo = r[63:0];
    res.res_hi = r[127:64];
  end

endmodule

`default_nettype wire

/* rtl/core/ssbi_out_stage.sv */
// result register with stream handshake
`default_nettype none

module ssbi_out_stage
  import ssbi_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire res_item_t        result,
  output logic                  take,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata
);

  res_item_t held;

  // the register moves on when empty or when its item is taken
  assign take = !m_tvalid || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= in_valid;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (in_valid && take) begin
      held <= result;
    end
  end

  assign m_tdata = {(OUT_W - $bits(res_item_t))'(0), held};

endmodule

`default_nettype wire

/* rtl/core/simd_shift_by_immediate_unit.sv */
// top level of the simd shift-by-immediate unit
// path: an accepted item is held in the input register, then in the result register,
//   where m_tvalid presents it until it is taken
// throughput: one item per cycle; the input register and the result register both
//   advance whenever the result register is empty or its item is taken
// reset: synchronous rst clears both valid flags; the payload registers are not reset
`default_nettype none

module simd_shift_by_immediate_unit
  import ssbi_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // mode[3:0], q[4], immh[8:5], immb[11:9], src_lo[75:12], src_hi[139:76],
  // dst_lo[203:140], dst_hi[267:204], zero pad[271:268]
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // res_lo[63:0], res_hi[127:64], status[129:128], zero pad[135:130]
  output logic [OUT_W-1:0]      m_tdata
);

  op_item_t  item;
  dec_t      dec;
  res_item_t result;
  logic      item_valid;
  logic      take;

  // input register
  ssbi_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .valid    (item_valid),
    .item     (item)
  );

  // decode of the immediate
  ssbi_decode u_dec (
    .item (item),
    .dec  (dec)
  );

  // lane datapath
  ssbi_lanes u_lanes (
    .item (item),
    .dec  (dec),
    .res  (result)
  );

  // result register
  ssbi_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_valid),
    .result   (result),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

/* rtl/core/ssbi_checker.sv */
// port-level checks for the simd shift-by-immediate unit, bound to the top level
`default_nettype none

module ssbi_checker
  import ssbi_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // an empty result register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // an accepted item reaches the output if the sink is ready while it sits in the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
    else $error("accepted item did not reach the output");

  // status is always one of the defined codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[129:128] == ST_OK || m_tdata[129:128] == ST_DECODE ||
                  m_tdata[129:128] == ST_RESERVED))
    else $error("unused status code");

endmodule

bind simd_shift_by_immediate_unit ssbi_checker u_ssbi_checker (.*);

`default_nettype wire

/* bench/testbench.sv */
// self-checking stream testbench for the simd shift-by-immediate unit
`timescale 1ns / 1ps

module testbench;
  import ssbi_pkg::*;

  localparam int RANDOM_PER_PHASE = 500;
  localparam int LONG_HOLD        = 300;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int PRINT_CAP        = 40;

  // expected destination vectors, one per accepted instruction
  class vec_shift_scoreboard;
    res_item_t   expected_dests[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      mismatches   = 0;
      results_seen = 0;
    endfunction

    task flag_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      if (mismatches < PRINT_CAP)
        $display("mismatch at result %0d, %s: got %h expected %h",
                 results_seen, what, got, want);
      mismatches++;
    endtask

    // new destination vector for one shift-by-immediate instruction
    function res_item_t predict_dest(input op_item_t it);
      res_item_t    r;
      logic [127:0] src;
      logic [127:0] dst;
      logic [127:0] acc;
      logic [127:0] lmask;
      logic [127:0] wmask;
      logic [127:0] x;
      logic [127:0] d;
      logic [127:0] v;
      logic [127:0] m;
      logic [6:0]   imm;
      int           esz;
      int           rsh;
      int           lsh;
      int           lanes;
      int           i;
      src      = {it.src_hi, it.src_lo};
      dst      = {it.dst_hi, it.dst_lo};
      r.res_lo = it.dst_lo;
      r.res_hi = it.dst_hi;
      r.status = ST_OK;
      // decode error and reserved encodings leave the destination alone
      if (it.immh == 4'd0) begin
        r.status = ST_DECODE;
        return r;
      end
      if (it.mode > OP_USHLL || (it.immh[3] && (it.mode >= OP_SHRN || !it.q))) begin
        r.status = ST_RESERVED;
        return r;
      end
      esz   = it.immh[3] ? 64 : it.immh[2] ? 32 : it.immh[1] ? 16 : 8;
      imm   = {it.immh, it.immb};
      rsh   = 2 * esz - int'(imm);
      lsh   = int'(imm) - esz;
      lmask = (128'd1 << esz) - 128'd1;
      wmask = (128'd1 << (2 * esz)) - 128'd1;
      acc   = '0;
      if (it.mode <= OP_SRI) begin
        // same-size lanes across 64 or 128 bits
        lanes = (it.q ? 128 : 64) / esz;
        for (i = 0; i < lanes; i++) begin
          x = (src >> (i * esz)) & lmask;
          d = (dst >> (i * esz)) & lmask;
          if (it.mode <= OP_URSRA) begin
            v = x;
            if (!it.mode[0] && x[esz-1]) v = x | ~lmask;
            v = $signed(v) >>> rsh;
            if (it.mode >= OP_SRSHR && x[rsh-1]) v = v + 128'd1;
            if (it.mode == OP_SSRA || it.mode == OP_USRA ||
                it.mode == OP_SRSRA || it.mode == OP_URSRA) v = v + d;
          end else if (it.mode == OP_SHL) begin
            v = x << lsh;
          end else if (it.mode == OP_SLI) begin
            m = (lmask << lsh) & lmask;
            v = (d & ~m) | (x << lsh);
          end else begin
            m = lmask >> rsh;
            v = (d & ~m) | (x >> rsh);
          end
          acc = acc | ((v & lmask) << (i * esz));
        end
      end else if (it.mode <= OP_RSHRN) begin
        // narrowing: double-width source lanes into one 64-bit half
        lanes = 64 / esz;
        for (i = 0; i < lanes; i++) begin
          x = (src >> (i * 2 * esz)) & wmask;
          v = x >> rsh;
          if (it.mode == OP_RSHRN && x[rsh-1]) v = v + 128'd1;
          acc = acc | ((v & lmask) << (i * esz));
        end
        if (it.q) acc = {acc[63:0], it.dst_lo};
        else acc = {64'd0, acc[63:0]};
      end else begin
        // widening from the low or high source half
        lanes = 64 / esz;
        for (i = 0; i < lanes; i++) begin
          x = ((it.q ? {64'd0, it.src_hi} : {64'd0, it.src_lo}) >> (i * esz)) & lmask;
          if (it.mode == OP_SSHLL && x[esz-1]) x = x | ~lmask;
          v = (x << lsh) & wmask;
          acc = acc | (v << (i * 2 * esz));
        end
      end
      r.res_lo = acc[63:0];
      r.res_hi = acc[127:64];
      return r;
    endfunction

    function void note_instr(input op_item_t it);
      expected_dests.push_back(predict_dest(it));
    endfunction

    task check_result(input res_item_t got);
      res_item_t want;
      if (expected_dests.size() == 0) begin
        flag_mismatch("result with nothing pending", got.res_lo, 64'd0);
      end else begin
        want = expected_dests.pop_front();
        if (got.res_lo !== want.res_lo) flag_mismatch("res_lo", got.res_lo, want.res_lo);
        if (got.res_hi !== want.res_hi) flag_mismatch("res_hi", got.res_hi, want.res_hi);
        if (got.status !== want.status)
          flag_mismatch("status", {62'd0, got.status}, {62'd0, want.status});
      end
      results_seen++;
    endtask

    function int backlog();
      return expected_dests.size();
    endfunction
  endclass

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  vec_shift_scoreboard book = new();
  int                  send_idle_pct  = 29;
  int                  recv_idle_pct  = 51;
  int                  hold_off_asks  = 0;
  int                  hold_off_taken = 0;
  int                  quiet_cycles   = 0;

  simd_shift_by_immediate_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_asks != hold_off_taken) begin
        hold_off_taken++;
        m_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // monitor both sides and watch for a stuck pipe
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) book.note_instr(op_item_t'(s_tdata[$bits(op_item_t)-1:0]));
      if (m_tvalid && m_tready) book.check_result(res_item_t'(m_tdata[$bits(res_item_t)-1:0]));
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // data word biased towards lane extremes
  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(7))
      0:       w = '1;
      1:       w = '0;
      2:       w = w | 64'h8080_8080_8080_8080;
      3:       w = w & 64'h7F7F_7F7F_7F7F_7F7F;
      4:       w = w | 64'h8000_8000_8000_8000;
      default: ;
    endcase
    return w;
  endfunction

  function automatic op_item_t make_instr(input logic [3:0] mode, input logic q,
                                          input logic [3:0] immh, input logic [2:0] immb,
                                          input logic [63:0] slo, input logic [63:0] shi,
                                          input logic [63:0] dlo, input logic [63:0] dhi);
    op_item_t it;
    it.mode   = mode;
    it.q      = q;
    it.immh   = immh;
    it.immb   = immb;
    it.src_lo = slo;
    it.src_hi = shi;
    it.dst_lo = dlo;
    it.dst_hi = dhi;
    return it;
  endfunction

  // mostly valid encodings with random content, some raw noise
  function automatic op_item_t random_instr();
    op_item_t it;
    int       k;
    it = make_instr(OP_SSHR, 1'($urandom_range(1)), 4'd1, 3'($urandom_range(7)),
                    rand_word(), rand_word(), rand_word(), rand_word());
    if ($urandom_range(99) < 88) begin
      it.mode = 4'($urandom_range(OP_USHLL));
      k = (it.mode >= OP_SHRN) ? $urandom_range(2) : $urandom_range(3);
      if (k == 3) it.q = 1'b1;
      it.immh = (4'd1 << k) | 4'($urandom_range((1 << k) - 1));
    end else begin
      it.mode = 4'($urandom_range(15));
      it.immh = 4'($urandom_range(15));
    end
    return it;
  endfunction

  task automatic issue_instr(input op_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - $bits(op_item_t)){1'b0}}, it};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop offering and wait for every pending result
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (book.backlog() != 0) @(posedge clk);
  endtask

  initial begin
    logic [3:0] m;
    int         k;
    int         n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every operation once, at the shift extreme picked by the low bit of the mode
    for (n = 0; n <= OP_USHLL; n++) begin
      m = 4'(n);
      k = (m >= OP_SHRN) ? n % 3 : n % 4;
      issue_instr(make_instr(m, (k == 3) || m[1],
                             m[0] ? 4'((2 << k) - 1) : 4'(1 << k), m[0] ? 3'd7 : 3'd0,
                             (n % 3 == 0) ? '1 : 64'h8000_8000_8080_8080,
                             (n % 3 == 0) ? 64'h8000_0000_8000_0080 : '1,
                             rand_word(), rand_word()));
    end
    // decode error and reserved encodings
    issue_instr(make_instr(OP_SSHR, 1'b1, 4'd0, 3'd5, '1, '1, 64'h0123_4567_89AB_CDEF, '1));
    issue_instr(make_instr(OP_UNDEF, 1'b1, 4'd1, 3'd0, '1, '1, 64'hFEDC_BA98_7654_3210, '0));
    issue_instr(make_instr(OP_SHL, 1'b0, 4'd8, 3'd3, '1, '1, '0, '1));
    issue_instr(make_instr(OP_SHRN, 1'b1, 4'd8, 3'd1, '1, '1, '1, '0));
    issue_instr(make_instr(OP_USHLL, 1'b1, 4'hF, 3'd7, '1, '1, '0, '0));
    // rounding carries, all-ones accumulate and a zero source
    issue_instr(make_instr(OP_URSRA, 1'b1, 4'hF, 3'd7, '1, '1, '1, '1));
    issue_instr(make_instr(OP_RSHRN, 1'b1, 4'd4, 3'd0, '1, '1, '1, '1));
    issue_instr(make_instr(OP_SRSHR, 1'b1, 4'd8, 3'd0, 64'h8000_0000_0000_0000,
                           64'h7FFF_FFFF_FFFF_FFFF, '0, '0));
    issue_instr(make_instr(OP_SSHR, 1'b0, 4'd2, 3'd0, '0, '0, '1, '1));

    // random, receiver stalls more than the sender, long hold-off partway
    for (n = 0; n < RANDOM_PER_PHASE; n++) begin
      if (n == 100) hold_off_asks++;
      issue_instr(random_instr());
    end
    drain();

    // random, sender idles more
    send_idle_pct = 51;
    recv_idle_pct = 29;
    for (n = 0; n < RANDOM_PER_PHASE; n++) issue_instr(random_instr());
    drain();

    // random, back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (n = 0; n < RANDOM_PER_PHASE; n++) issue_instr(random_instr());
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.backlog() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/ssbi_pkg.sv
rtl/core/ssbi_in_stage.sv
rtl/core/ssbi_decode.sv
rtl/core/ssbi_lanes.sv
rtl/core/ssbi_out_stage.sv
rtl/core/simd_shift_by_immediate_unit.sv
rtl/core/ssbi_checker.sv
bench/testbench.sv
